### sv/uvs_pkg.sv
package uvs_pkg;

  localparam int MAX_SLICES = 1024;
  localparam int MAX_STACKS = 1024;

  localparam int IDX_W = 11;
  localparam int REC_W = 33;
  localparam int PROD_W = 44;
  localparam int VERT_W = 21;
  localparam int TEX_W = 17;
  localparam int POS_W = 17;
  localparam int NORM_W = 16;
  localparam int XY_W = 32;
  localparam int Z_W = 34;
  localparam int CORDIC_STEPS = 20;
  localparam int DIV_STEPS = 33;
  localparam int CNT_W = 6;

  localparam logic signed [XY_W-1:0] CORDIC_START = 32'sd652032874;
  localparam logic [REC_W-1:0] RECIP_32 = 33'h008000000;
  localparam logic [REC_W-1:0] RECIP_16 = 33'h010000000;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_SLICES = 2'd1,
    CFG_STACKS = 2'd2,
    CFG_INVERT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic              vld;
    logic              func;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic [VERT_W-1:0] va;
    logic [VERT_W-1:0] vb1;
    logic [VERT_W-1:0] vc1;
    logic [VERT_W-1:0] vb2;
    logic [1:0]        qu;
    logic [1:0]        qv;
  } tag_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  typedef struct packed {
    logic [1:0]            q;
    logic signed [Z_W-1:0] z;
  } red_t;

  function automatic logic signed [Z_W-1:0] atan_turn(input int k);
    logic [29:0] a;
    case (k)
      0: a = 30'h20000000;
      1: a = 30'h12E4051E;
      2: a = 30'h09FB385B;
      3: a = 30'h051111D4;
      4: a = 30'h028B0D43;
      5: a = 30'h0145D7E1;
      6: a = 30'h00A2F61E;
      7: a = 30'h00517C55;
      8: a = 30'h0028BE53;
      9: a = 30'h00145F2F;
      10: a = 30'h000A2F98;
      11: a = 30'h000517CC;
      12: a = 30'h00028BE6;
      13: a = 30'h000145F3;
      14: a = 30'h0000A2FA;
      15: a = 30'h0000517D;
      16: a = 30'h000028BE;
      17: a = 30'h0000145F;
      18: a = 30'h00000A30;
      19: a = 30'h00000518;
      default: a = 30'h0;
    endcase
    return $signed({4'b0, a});
  endfunction

  function automatic red_t reduce(input logic [31:0] ph);
    red_t r;
    logic [31:0] sum;
    logic [31:0] ru;
    sum = ph + 32'h2000_0000;
    r.q = sum[31:30];
    ru = ph - {r.q, 30'b0};
    r.z = Z_W'($signed(ru));
    return r;
  endfunction

  function automatic rot_t cordic_step(input rot_t a, input int k);
    rot_t r;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    dx = a.y >>> k;
    dy = a.x >>> k;
    if (a.z >= 0) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_turn(k);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_turn(k);
    end
    return r;
  endfunction

endpackage

### sv/uvs_recip.sv
module uvs_recip (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [uvs_pkg::IDX_W-1:0]      n,
  output logic                           busy,
  output logic                           done,
  output logic [uvs_pkg::REC_W-1:0]      quo
);

  logic                          run;
  logic [uvs_pkg::CNT_W-1:0]     cnt;
  logic [uvs_pkg::IDX_W-1:0]     rem;
  logic [uvs_pkg::IDX_W-1:0]     dvs;
  logic [uvs_pkg::REC_W-1:0]     dsh;
  logic [uvs_pkg::IDX_W:0]       rem_s;
  logic [uvs_pkg::IDX_W:0]       diff;
  logic                          ge;

  always_comb begin
    rem_s = {rem, dsh[uvs_pkg::REC_W-1]};
    diff = rem_s - {1'b0, dvs};
    ge = rem_s >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dvs <= n;
        dsh <= {1'b1, 32'(n[uvs_pkg::IDX_W-1:1])};
      end else if (run) begin
        rem <= ge ? diff[uvs_pkg::IDX_W-1:0] : rem_s[uvs_pkg::IDX_W-1:0];
        quo <= {quo[uvs_pkg::REC_W-2:0], ge};
        dsh <= {dsh[uvs_pkg::REC_W-2:0], 1'b0};
        cnt <= cnt + uvs_pkg::CNT_W'(1);
        if (cnt == uvs_pkg::CNT_W'(uvs_pkg::DIV_STEPS - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign busy = run | done;

endmodule

### sv/uv_sphere_vertex_generator.sv
// UV sphere vertex and triangle index generator.
// A request is accepted when start is high and busy is low. func 0 asks for
// the vertex at row_index and column_index, func 1 for the two triangles of
// the quad there. Results appear on the result ports for one cycle each,
// marked by strobe; last_of_run marks the final word of a request.
// A vertex request gives one word, a quad two triangle words, the second
// held in a pending register and sent right after the first. A request out
// of range, or any request while a division count is out of range, gives no
// word. Requests may follow one per cycle while busy is low; after a quad,
// busy is high for one cycle so the second triangle has its output slot.
// The depth is set by the twenty CORDIC iterations, one per stage, for both
// angles side by side. The configuration channel takes a word when cfg_valid
// and cfg_ready are high. A write of slice_count or stack_count starts a
// bit-serial reciprocal division, during which busy is high and cfg_ready low.
// Reset restores the register defaults and empties the pipeline; it needs no
// clearing pass. The receiver cannot stall, so results are never held.
module uv_sphere_vertex_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func,
  input  logic [uvs_pkg::IDX_W-1:0]           row_index,
  input  logic [uvs_pkg::IDX_W-1:0]           column_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data,
  output logic                                strobe,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]    pos_z,
  output logic signed [uvs_pkg::NORM_W-1:0]   norm_x,
  output logic signed [uvs_pkg::NORM_W-1:0]   norm_y,
  output logic signed [uvs_pkg::NORM_W-1:0]   norm_z,
  output logic [uvs_pkg::TEX_W-1:0]           tex_u,
  output logic [uvs_pkg::TEX_W-1:0]           tex_v,
  output logic [uvs_pkg::VERT_W-1:0]          vert_a,
  output logic [uvs_pkg::VERT_W-1:0]          vert_b,
  output logic [uvs_pkg::VERT_W-1:0]          vert_c,
  output logic                                last_of_run
);

  logic [15:0]                  radius;
  logic [uvs_pkg::IDX_W-1:0]    slice_count;
  logic [uvs_pkg::IDX_W-1:0]    stack_count;
  logic                         invert_normals;
  logic [uvs_pkg::REC_W-1:0]    rs;
  logic [uvs_pkg::REC_W-1:0]    rt;
  logic                         tgt_stack;

  logic                         dv_load;
  logic                         dv_busy;
  logic                         dv_done;
  logic [uvs_pkg::REC_W-1:0]    dv_quo;
  logic                         cfg_we;
  logic                         quad_hold;
  logic                         accept;
  logic                         cfg_ok;
  logic                         in_ok;

  logic                         a_vld;
  logic                         a_func;
  logic [uvs_pkg::IDX_W-1:0]    a_i;
  logic [uvs_pkg::IDX_W-1:0]    a_j;

  logic                         b_vld;
  logic                         b_func;
  logic [uvs_pkg::IDX_W-1:0]    b_j;
  logic [uvs_pkg::PROD_W-1:0]   b_pj;
  logic [uvs_pkg::PROD_W-1:0]   b_pi;
  logic [22:0]                  b_r1;

  logic [22:0]                  r2;
  logic [uvs_pkg::PROD_W-1:0]   tu_sum;
  logic [uvs_pkg::PROD_W-1:0]   tv_sum;
  logic [31:0]                  pv;
  uvs_pkg::red_t                red_u;
  uvs_pkg::red_t                red_v;

  uvs_pkg::tag_t                tg0;
  logic signed [uvs_pkg::Z_W-1:0] zu0;
  logic signed [uvs_pkg::Z_W-1:0] zv0;
  uvs_pkg::tag_t                tg [1:uvs_pkg::CORDIC_STEPS];
  uvs_pkg::rot_t                ru [1:uvs_pkg::CORDIC_STEPS];
  uvs_pkg::rot_t                rv [1:uvs_pkg::CORDIC_STEPS];

  uvs_pkg::tag_t                f_tg;
  logic signed [uvs_pkg::XY_W-1:0] f_cu;
  logic signed [uvs_pkg::XY_W-1:0] f_su;
  logic signed [uvs_pkg::XY_W-1:0] f_cv;
  logic signed [uvs_pkg::XY_W-1:0] f_sv;

  uvs_pkg::tag_t                m_tg;
  logic signed [uvs_pkg::XY_W-1:0] m_e [0:2];
  logic signed [63:0]           pcc;
  logic signed [63:0]           psc;

  logic signed [48:0]           pr [0:2];
  logic signed [48:0]           pp [0:2];
  logic signed [uvs_pkg::XY_W-1:0] nn [0:2];
  logic signed [uvs_pkg::POS_W-1:0] pos_c [0:2];
  logic signed [uvs_pkg::NORM_W-1:0] norm_c [0:2];

  logic                         pend;
  logic [uvs_pkg::VERT_W-1:0]   pend_a;
  logic [uvs_pkg::VERT_W-1:0]   pend_b;
  logic [uvs_pkg::VERT_W-1:0]   pend_c;

  uvs_recip u_recip (
    .clk  (clk),
    .rst  (rst),
    .load (dv_load),
    .n    (cfg_data[uvs_pkg::IDX_W-1:0]),
    .busy (dv_busy),
    .done (dv_done),
    .quo  (dv_quo)
  );

  assign cfg_ready = !dv_busy;
  assign cfg_we = cfg_valid && cfg_ready;
  assign dv_load = cfg_we && (cfg_index == uvs_pkg::CFG_SLICES ||
                              cfg_index == uvs_pkg::CFG_STACKS);
  assign busy = dv_busy || quad_hold;
  assign accept = start && !busy;

  always_comb begin
    cfg_ok = slice_count != '0 && slice_count <= uvs_pkg::IDX_W'(uvs_pkg::MAX_SLICES) &&
             stack_count != '0 && stack_count <= uvs_pkg::IDX_W'(uvs_pkg::MAX_STACKS);
    if (func) begin
      in_ok = row_index < stack_count && column_index < slice_count;
    end else begin
      in_ok = row_index <= stack_count && column_index <= slice_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      slice_count <= uvs_pkg::IDX_W'(32);
      stack_count <= uvs_pkg::IDX_W'(16);
      invert_normals <= 1'b0;
      rs <= uvs_pkg::RECIP_32;
      rt <= uvs_pkg::RECIP_16;
      tgt_stack <= 1'b0;
      quad_hold <= 1'b0;
    end else begin
      quad_hold <= accept && func;
      if (cfg_we) begin
        case (cfg_index)
          uvs_pkg::CFG_RADIUS: radius <= cfg_data;
          uvs_pkg::CFG_SLICES: begin
            slice_count <= cfg_data[uvs_pkg::IDX_W-1:0];
            tgt_stack <= 1'b0;
          end
          uvs_pkg::CFG_STACKS: begin
            stack_count <= cfg_data[uvs_pkg::IDX_W-1:0];
            tgt_stack <= 1'b1;
          end
          uvs_pkg::CFG_INVERT: invert_normals <= cfg_data[0];
          default: ;
        endcase
      end
      if (dv_done) begin
        if (tgt_stack) begin
          rt <= dv_quo;
        end else begin
          rs <= dv_quo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      a_vld <= accept && cfg_ok && in_ok;
      b_vld <= a_vld;
    end
    a_func <= func;
    a_i <= row_index;
    a_j <= column_index;
    b_func <= a_func;
    b_j <= a_j;
    b_pj <= uvs_pkg::PROD_W'(a_j) * uvs_pkg::PROD_W'(rs);
    b_pi <= uvs_pkg::PROD_W'(a_i) * uvs_pkg::PROD_W'(rt);
    b_r1 <= 23'(a_i) * 23'({1'b0, slice_count} + 12'd1);
  end

  always_comb begin
    r2 = b_r1 + 23'(slice_count) + 23'd1;
    tu_sum = b_pj + uvs_pkg::PROD_W'(32'h8000);
    tv_sum = b_pi + uvs_pkg::PROD_W'(32'h8000);
    pv = b_pi[32:1] - 32'h4000_0000;
    red_u = uvs_pkg::reduce(b_pj[31:0]);
    red_v = uvs_pkg::reduce(pv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tg0.vld <= 1'b0;
    end else begin
      tg0.vld <= b_vld;
    end
    tg0.func <= b_func;
    tg0.tex_u <= tu_sum[32:16];
    tg0.tex_v <= tv_sum[32:16];
    tg0.va <= uvs_pkg::VERT_W'(b_r1 + 23'(b_j));
    tg0.vb1 <= uvs_pkg::VERT_W'(r2 + 23'(b_j) + 23'd1);
    tg0.vc1 <= uvs_pkg::VERT_W'(r2 + 23'(b_j));
    tg0.vb2 <= uvs_pkg::VERT_W'(b_r1 + 23'(b_j) + 23'd1);
    tg0.qu <= red_u.q;
    tg0.qv <= red_v.q;
    zu0 <= red_u.z;
    zv0 <= red_v.z;
  end

  for (genvar k = 0; k < uvs_pkg::CORDIC_STEPS; k++) begin : g_cordic
    uvs_pkg::tag_t t_in;
    uvs_pkg::rot_t u_in;
    uvs_pkg::rot_t v_in;
    if (k == 0) begin : g_first
      always_comb begin
        t_in = tg0;
        u_in = '{x: uvs_pkg::CORDIC_START, y: '0, z: zu0};
        v_in = '{x: uvs_pkg::CORDIC_START, y: '0, z: zv0};
      end
    end else begin : g_next
      always_comb begin
        t_in = tg[k];
        u_in = ru[k];
        v_in = rv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k+1].vld <= 1'b0;
      end else begin
        tg[k+1].vld <= t_in.vld;
      end
      tg[k+1].func <= t_in.func;
      tg[k+1].tex_u <= t_in.tex_u;
      tg[k+1].tex_v <= t_in.tex_v;
      tg[k+1].va <= t_in.va;
      tg[k+1].vb1 <= t_in.vb1;
      tg[k+1].vc1 <= t_in.vc1;
      tg[k+1].vb2 <= t_in.vb2;
      tg[k+1].qu <= t_in.qu;
      tg[k+1].qv <= t_in.qv;
      ru[k+1] <= uvs_pkg::cordic_step(u_in, k);
      rv[k+1] <= uvs_pkg::cordic_step(v_in, k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_tg.vld <= 1'b0;
    end else begin
      f_tg.vld <= tg[uvs_pkg::CORDIC_STEPS].vld;
    end
    f_tg.func <= tg[uvs_pkg::CORDIC_STEPS].func;
    f_tg.tex_u <= tg[uvs_pkg::CORDIC_STEPS].tex_u;
    f_tg.tex_v <= tg[uvs_pkg::CORDIC_STEPS].tex_v;
    f_tg.va <= tg[uvs_pkg::CORDIC_STEPS].va;
    f_tg.vb1 <= tg[uvs_pkg::CORDIC_STEPS].vb1;
    f_tg.vc1 <= tg[uvs_pkg::CORDIC_STEPS].vc1;
    f_tg.vb2 <= tg[uvs_pkg::CORDIC_STEPS].vb2;
    f_tg.qu <= tg[uvs_pkg::CORDIC_STEPS].qu;
    f_tg.qv <= tg[uvs_pkg::CORDIC_STEPS].qv;
    case (tg[uvs_pkg::CORDIC_STEPS].qu)
      2'd0: begin
        f_cu <= ru[uvs_pkg::CORDIC_STEPS].x;
        f_su <= ru[uvs_pkg::CORDIC_STEPS].y;
      end
      2'd1: begin
        f_cu <= -ru[uvs_pkg::CORDIC_STEPS].y;
        f_su <= ru[uvs_pkg::CORDIC_STEPS].x;
      end
      2'd2: begin
        f_cu <= -ru[uvs_pkg::CORDIC_STEPS].x;
        f_su <= -ru[uvs_pkg::CORDIC_STEPS].y;
      end
      default: begin
        f_cu <= ru[uvs_pkg::CORDIC_STEPS].y;
        f_su <= -ru[uvs_pkg::CORDIC_STEPS].x;
      end
    endcase
    case (tg[uvs_pkg::CORDIC_STEPS].qv)
      2'd0: begin
        f_cv <= rv[uvs_pkg::CORDIC_STEPS].x;
        f_sv <= rv[uvs_pkg::CORDIC_STEPS].y;
      end
      2'd1: begin
        f_cv <= -rv[uvs_pkg::CORDIC_STEPS].y;
        f_sv <= rv[uvs_pkg::CORDIC_STEPS].x;
      end
      2'd2: begin
        f_cv <= -rv[uvs_pkg::CORDIC_STEPS].x;
        f_sv <= -rv[uvs_pkg::CORDIC_STEPS].y;
      end
      default: begin
        f_cv <= rv[uvs_pkg::CORDIC_STEPS].y;
        f_sv <= -rv[uvs_pkg::CORDIC_STEPS].x;
      end
    endcase
  end

  always_comb begin
    pcc = (64'(f_cu) * 64'(f_cv) + 64'sd536870912) >>> 30;
    psc = (64'(f_su) * 64'(f_cv) + 64'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tg.vld <= 1'b0;
    end else begin
      m_tg.vld <= f_tg.vld;
    end
    m_tg.func <= f_tg.func;
    m_tg.tex_u <= f_tg.tex_u;
    m_tg.tex_v <= f_tg.tex_v;
    m_tg.va <= f_tg.va;
    m_tg.vb1 <= f_tg.vb1;
    m_tg.vc1 <= f_tg.vc1;
    m_tg.vb2 <= f_tg.vb2;
    m_tg.qu <= f_tg.qu;
    m_tg.qv <= f_tg.qv;
    m_e[0] <= pcc[31:0];
    m_e[1] <= psc[31:0];
    m_e[2] <= f_sv;
  end

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      pr[d] = $signed({33'b0, radius}) * 49'(m_e[d]);
      pp[d] = (pr[d] + 49'sd536870912) >>> 30;
      nn[d] = (m_e[d] + 32'sd32768) >>> 16;
      if (pp[d] > 49'sd65535) begin
        pos_c[d] = 17'sd65535;
      end else if (pp[d] < -49'sd65535) begin
        pos_c[d] = -17'sd65535;
      end else begin
        pos_c[d] = pp[d][uvs_pkg::POS_W-1:0];
      end
      if (nn[d] > 32'sd16384) begin
        norm_c[d] = 16'sd16384;
      end else if (nn[d] < -32'sd16384) begin
        norm_c[d] = -16'sd16384;
      end else begin
        norm_c[d] = nn[d][uvs_pkg::NORM_W-1:0];
      end
      if (invert_normals) begin
        norm_c[d] = -norm_c[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend <= 1'b0;
    end else begin
      strobe <= m_tg.vld || pend;
      pend <= m_tg.vld && m_tg.func;
    end
    pend_a <= m_tg.va;
    pend_b <= m_tg.vb2;
    pend_c <= m_tg.vb1;
    if (m_tg.vld && !m_tg.func) begin
      pos_x <= pos_c[0];
      pos_y <= pos_c[1];
      pos_z <= pos_c[2];
      norm_x <= norm_c[0];
      norm_y <= norm_c[1];
      norm_z <= norm_c[2];
      tex_u <= m_tg.tex_u;
      tex_v <= m_tg.tex_v;
      vert_a <= '0;
      vert_b <= '0;
      vert_c <= '0;
      last_of_run <= 1'b1;
    end else begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      norm_x <= '0;
      norm_y <= '0;
      norm_z <= '0;
      tex_u <= '0;
      tex_v <= '0;
      if (m_tg.vld) begin
        vert_a <= m_tg.va;
        vert_b <= m_tg.vb1;
        vert_c <= m_tg.vc1;
        last_of_run <= 1'b0;
      end else begin
        vert_a <= pend_a;
        vert_b <= pend_b;
        vert_c <= pend_c;
        last_of_run <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_quad_gap: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func |=> busy)
    else $error("quad accepted without a blocked slot after it");

  a_tri_pair: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_run |=> strobe && last_of_run)
    else $error("first triangle not followed by the second");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == uvs_pkg::CFG_SLICES ||
      cfg_index == uvs_pkg::CFG_STACKS) |=> busy && !cfg_ready)
    else $error("reciprocal update not holding off requests");
`endif

endmodule
